@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. They compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset.
`define DTC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a rising edge outside reset.
`define DTC_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define DTC_ASSERT(lbl, clk, rst_n, prop, msg)
`define DTC_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

@@ hw/rtl/dtc8051_pkg.sv @@
package dtc8051_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		SEL_T0_LO = 2'd0,
		SEL_T0_HI = 2'd1,
		SEL_T1_LO = 2'd2,
		SEL_T1_HI = 2'd3
	} sel_t;

	// Timer 1 treats MODE_SPLIT as halted.
	typedef enum logic [1:0] {
		MODE_13BIT  = 2'd0,
		MODE_16BIT  = 2'd1,
		MODE_RELOAD = 2'd2,
		MODE_SPLIT  = 2'd3
	} mode_t;

	localparam logic CFG_T0_MODE = 1'b0;
	localparam logic CFG_T1_MODE = 1'b1;

	typedef struct packed {
		logic [7:0] lo;
		logic [7:0] hi;
		logic       ovf;
	} timer_t;

	typedef struct packed {
		logic [7:0] t0_low;
		logic [7:0] t0_high;
		logic [7:0] t1_low;
		logic [7:0] t1_high;
		logic       flag0;
		logic       flag1;
	} result_t;

	// One tick of a timer in modes 13-bit, 16-bit or auto-reload.
	// Any other mode leaves the count alone.
	function automatic timer_t timer_adv(mode_t mode, logic [7:0] lo, logic [7:0] hi,
			logic [7:0] cyc);
		timer_t     r;
		logic [13:0] sum13;
		logic [16:0] sum16;
		logic [8:0]  sum9;
		sum13 = {1'b0, hi, lo[4:0]} + {6'd0, cyc};
		sum16 = {1'b0, hi, lo} + {9'd0, cyc};
		sum9  = {1'b0, lo} + {1'b0, cyc};
		r.lo  = lo;
		r.hi  = hi;
		r.ovf = 1'b0;
		case (mode)
			MODE_13BIT: begin
				r.lo  = {3'd0, sum13[4:0]};
				r.hi  = sum13[12:5];
				r.ovf = sum13[13];
			end
			MODE_16BIT: begin
				r.lo  = sum16[7:0];
				r.hi  = sum16[15:8];
				r.ovf = sum16[16];
			end
			MODE_RELOAD: begin
				// On overflow the excess past 0x100 is added to the reload value.
				r.lo  = sum9[8] ? (hi + sum9[7:0]) : sum9[7:0];
				r.ovf = sum9[8];
			end
			default: begin
				r.lo  = lo;
			end
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/dual_timer_counter_8051.sv @@
// Two 8051-style timers with sticky overflow flags.
// Input channel (in_valid / in_stall) carries one item per cycle: a tick that adds
// cycles to each running timer, a count byte write, or a flag clear. Every item
// yields exactly one result on the output channel (out_valid / out_stall): the
// four count bytes and both flags as they stand after that item.
// An accepted item's result goes to the result register, or to the skid
// register if that is stalled. Throughput is one item per cycle while in_stall
// is low; each timer update is a single add between state and result registers.
// A skid register sits behind the result register, so one more item is taken
// while a result is stalled; in_stall rises only once that skid entry is full.
// Configuration (cfg_valid / cfg_ready, always ready) selects the timer modes
// and must be written only while no item is in flight.
// Reset clears all counts, flags and modes and empties the output stages.
`include "assert_macros.svh"

module dual_timer_counter_8051 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] op,
	input  logic [1:0] reg_select,
	input  logic [7:0] write_data,
	input  logic [7:0] cycles,
	input  logic       run_timer0,
	input  logic       run_timer1,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_t0_low,
	output logic [7:0] out_t0_high,
	output logic [7:0] out_t1_low,
	output logic [7:0] out_t1_high,
	output logic       out_flag0,
	output logic       out_flag1,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [1:0] cfg_data
);

	dtc8051_pkg::mode_t t0_mode_q, t1_mode_q;
	logic [7:0] t0_lo_q, t0_hi_q, t1_lo_q, t1_hi_q;
	logic       flag0_q, flag1_q;

	dtc8051_pkg::result_t nxt;
	dtc8051_pkg::result_t res_q, skid_q;
	logic       res_valid_q, skid_valid_q;

	dtc8051_pkg::timer_t t0_adv, t1_adv;
	logic [8:0] split_lo, split_hi;
	logic       split;
	logic       in_acc, out_acc, cfg_acc;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid & cfg_ready;
	assign in_stall  = skid_valid_q;
	assign in_acc    = in_valid & ~in_stall;
	assign out_acc   = res_valid_q & ~out_stall;

	assign split    = (t0_mode_q == dtc8051_pkg::MODE_SPLIT);
	assign t0_adv   = dtc8051_pkg::timer_adv(t0_mode_q, t0_lo_q, t0_hi_q, cycles);
	assign t1_adv   = dtc8051_pkg::timer_adv(t1_mode_q, t1_lo_q, t1_hi_q, cycles);
	assign split_lo = {1'b0, t0_lo_q} + {1'b0, cycles};
	assign split_hi = {1'b0, t0_hi_q} + {1'b0, cycles};

	always_comb begin
		nxt.t0_low  = t0_lo_q;
		nxt.t0_high = t0_hi_q;
		nxt.t1_low  = t1_lo_q;
		nxt.t1_high = t1_hi_q;
		nxt.flag0   = flag0_q;
		nxt.flag1   = flag1_q;
		case (op)
			dtc8051_pkg::OP_TICK: begin
				if (split) begin
					// Low byte runs on run_timer0 / flag 0, high byte on run_timer1 / flag 1.
					if (run_timer0) begin
						nxt.t0_low = split_lo[7:0];
						nxt.flag0  = flag0_q | split_lo[8];
					end
					if (run_timer1) begin
						nxt.t0_high = split_hi[7:0];
						nxt.flag1   = flag1_q | split_hi[8];
					end
				end else if (run_timer0) begin
					nxt.t0_low  = t0_adv.lo;
					nxt.t0_high = t0_adv.hi;
					nxt.flag0   = flag0_q | t0_adv.ovf;
				end
				// Timer 1 in mode 3 is left unchanged by timer_adv.
				if (run_timer1) begin
					nxt.t1_low  = t1_adv.lo;
					nxt.t1_high = t1_adv.hi;
					if (!split) begin
						nxt.flag1 = flag1_q | t1_adv.ovf;
					end
				end
			end
			dtc8051_pkg::OP_WRITE: begin
				unique case (dtc8051_pkg::sel_t'(reg_select))
					dtc8051_pkg::SEL_T0_LO: nxt.t0_low  = write_data;
					dtc8051_pkg::SEL_T0_HI: nxt.t0_high = write_data;
					dtc8051_pkg::SEL_T1_LO: nxt.t1_low  = write_data;
					dtc8051_pkg::SEL_T1_HI: nxt.t1_high = write_data;
					default: nxt.t0_low = t0_lo_q;
				endcase
			end
			dtc8051_pkg::OP_CLEAR: begin
				nxt.flag0 = flag0_q & ~write_data[0];
				nxt.flag1 = flag1_q & ~write_data[1];
			end
			default: begin
				nxt.flag0 = flag0_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t0_mode_q <= dtc8051_pkg::MODE_13BIT;
			t1_mode_q <= dtc8051_pkg::MODE_13BIT;
		end else if (cfg_acc) begin
			unique case (cfg_index)
				dtc8051_pkg::CFG_T0_MODE: t0_mode_q <= dtc8051_pkg::mode_t'(cfg_data);
				dtc8051_pkg::CFG_T1_MODE: t1_mode_q <= dtc8051_pkg::mode_t'(cfg_data);
				default: t0_mode_q <= t0_mode_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t0_lo_q <= 8'd0;
			t0_hi_q <= 8'd0;
			t1_lo_q <= 8'd0;
			t1_hi_q <= 8'd0;
			flag0_q <= 1'b0;
			flag1_q <= 1'b0;
		end else if (in_acc) begin
			t0_lo_q <= nxt.t0_low;
			t0_hi_q <= nxt.t0_high;
			t1_lo_q <= nxt.t1_low;
			t1_hi_q <= nxt.t1_high;
			flag0_q <= nxt.flag0;
			flag1_q <= nxt.flag1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_acc || !res_valid_q) begin
			res_valid_q  <= skid_valid_q | in_acc;
			skid_valid_q <= 1'b0;
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_acc || !res_valid_q) begin
			res_q <= skid_valid_q ? skid_q : nxt;
		end else if (in_acc) begin
			skid_q <= nxt;
		end
	end

	assign out_valid   = res_valid_q;
	assign out_t0_low  = res_q.t0_low;
	assign out_t0_high = res_q.t0_high;
	assign out_t1_low  = res_q.t1_low;
	assign out_t1_high = res_q.t1_high;
	assign out_flag0   = res_q.flag0;
	assign out_flag1   = res_q.flag1;

	`DTC_NEVER(a_skid_without_result, clk, arst_n,
		skid_valid_q && !res_valid_q,
		"skid item held with empty result register")
	`DTC_ASSERT(a_stalled_item_to_skid, clk, arst_n,
		in_acc && res_valid_q && out_stall |=> skid_valid_q,
		"item taken during output stall was not parked in skid")
	`DTC_ASSERT(a_mode0_low_trim, clk, arst_n,
		in_acc && op == dtc8051_pkg::OP_TICK && run_timer0
			&& t0_mode_q == dtc8051_pkg::MODE_13BIT |=> t0_lo_q[7:5] == 3'd0,
		"13-bit tick left upper low-byte bits set")

endmodule

@@ bench/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	class timer_scoreboard;
		dtc8051_pkg::mode_t   t0_mode;
		dtc8051_pkg::mode_t   t1_mode;
		logic [7:0]           t0_lo;
		logic [7:0]           t0_hi;
		logic [7:0]           t1_lo;
		logic [7:0]           t1_hi;
		logic                 flag0;
		logic                 flag1;
		dtc8051_pkg::result_t expected_counts[$];
		int                   mismatches;

		function new();
			t0_mode    = dtc8051_pkg::MODE_13BIT;
			t1_mode    = dtc8051_pkg::MODE_13BIT;
			t0_lo      = 8'd0;
			t0_hi      = 8'd0;
			t1_lo      = 8'd0;
			t1_hi      = 8'd0;
			flag0      = 1'b0;
			flag1      = 1'b0;
			mismatches = 0;
		endfunction

		function void set_mode(logic idx, dtc8051_pkg::mode_t m);
			if (idx == dtc8051_pkg::CFG_T0_MODE) begin
				t0_mode = m;
			end else begin
				t1_mode = m;
			end
		endfunction

		function int pending();
			return expected_counts.size();
		endfunction

		// Returns 1 when the count passes the top of its range.
		function bit advance_count(dtc8051_pkg::mode_t m, inout logic [7:0] lo,
				inout logic [7:0] hi, input logic [7:0] cyc);
			int unsigned v;
			case (m)
				dtc8051_pkg::MODE_13BIT: begin
					v = 32'({hi, lo[4:0]});
					v = v + 32'(cyc);
					lo = {3'd0, v[4:0]};
					hi = v[12:5];
					return v > 32'h1FFF;
				end
				dtc8051_pkg::MODE_16BIT: begin
					v = 32'({hi, lo});
					v = v + 32'(cyc);
					lo = v[7:0];
					hi = v[15:8];
					return v > 32'hFFFF;
				end
				dtc8051_pkg::MODE_RELOAD: begin
					v = 32'(lo);
					v = v + 32'(cyc);
					if (v > 32'hFF) begin
						lo = hi + v[7:0];
						return 1'b1;
					end
					lo = v[7:0];
					return 1'b0;
				end
				default: begin
					return 1'b0;
				end
			endcase
		endfunction

		function bit count8(inout logic [7:0] b, input logic [7:0] cyc);
			int unsigned v;
			v = 32'(b);
			v = v + 32'(cyc);
			b = v[7:0];
			return v > 32'hFF;
		endfunction

		function void note_item(dtc8051_pkg::op_t o, dtc8051_pkg::sel_t s, logic [7:0] data,
				logic [7:0] cyc, logic r0, logic r1);
			bit split;
			dtc8051_pkg::result_t r;
			split = (t0_mode == dtc8051_pkg::MODE_SPLIT);
			case (o)
				dtc8051_pkg::OP_TICK: begin
					if (split) begin
						if (r0) begin
							if (count8(t0_lo, cyc)) flag0 = 1'b1;
						end
						if (r1) begin
							if (count8(t0_hi, cyc)) flag1 = 1'b1;
						end
					end else if (r0) begin
						if (advance_count(t0_mode, t0_lo, t0_hi, cyc)) flag0 = 1'b1;
					end
					// With timer 0 split, timer 1 keeps counting but loses its flag.
					if (t1_mode != dtc8051_pkg::MODE_SPLIT && r1) begin
						if (advance_count(t1_mode, t1_lo, t1_hi, cyc) && !split) begin
							flag1 = 1'b1;
						end
					end
				end
				dtc8051_pkg::OP_WRITE: begin
					case (s)
						dtc8051_pkg::SEL_T0_LO: t0_lo = data;
						dtc8051_pkg::SEL_T0_HI: t0_hi = data;
						dtc8051_pkg::SEL_T1_LO: t1_lo = data;
						default:                t1_hi = data;
					endcase
				end
				dtc8051_pkg::OP_CLEAR: begin
					if (data[0]) flag0 = 1'b0;
					if (data[1]) flag1 = 1'b0;
				end
				default: begin
				end
			endcase
			r.t0_low  = t0_lo;
			r.t0_high = t0_hi;
			r.t1_low  = t1_lo;
			r.t1_high = t1_hi;
			r.flag0   = flag0;
			r.flag1   = flag1;
			expected_counts.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
			if (exp_val != act_val) begin
				mismatches++;
				$display("%0t: %s expected %0h, got %0h", $realtime, name, exp_val, act_val);
			end
		endfunction

		function void check_result(dtc8051_pkg::result_t act);
			dtc8051_pkg::result_t e;
			if (expected_counts.size() == 0) begin
				mismatches++;
				$display("%0t: result with no item pending, got %h", $realtime, act);
				return;
			end
			e = expected_counts.pop_front();
			compare_field("t0_low", e.t0_low, act.t0_low);
			compare_field("t0_high", e.t0_high, act.t0_high);
			compare_field("t1_low", e.t1_low, act.t1_low);
			compare_field("t1_high", e.t1_high, act.t1_high);
			compare_field("flag0", {7'd0, e.flag0}, {7'd0, act.flag0});
			compare_field("flag1", {7'd0, e.flag1}, {7'd0, act.flag1});
		endfunction
	endclass

	localparam int RANDOM_PHASES = 16;
	localparam int PHASE_ITEMS   = 103;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_stall;
	logic [1:0] op         = 2'd0;
	logic [1:0] reg_select = 2'd0;
	logic [7:0] write_data = 8'd0;
	logic [7:0] cycles     = 8'd0;
	logic       run_timer0 = 1'b0;
	logic       run_timer1 = 1'b0;
	logic       out_valid;
	logic       out_stall  = 1'b0;
	logic [7:0] out_t0_low;
	logic [7:0] out_t0_high;
	logic [7:0] out_t1_low;
	logic [7:0] out_t1_high;
	logic       out_flag0;
	logic       out_flag1;
	logic       cfg_valid  = 1'b0;
	logic       cfg_ready;
	logic       cfg_index  = 1'b0;
	logic [1:0] cfg_data   = 2'd0;

	timer_scoreboard sb;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_off       = 0;
	bit hold_req       = 1'b0;
	bit hold_done      = 1'b0;

	dual_timer_counter_8051 u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.reg_select  (reg_select),
		.write_data  (write_data),
		.cycles      (cycles),
		.run_timer0  (run_timer0),
		.run_timer1  (run_timer1),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_t0_low  (out_t0_low),
		.out_t0_high (out_t0_high),
		.out_t1_low  (out_t1_low),
		.out_t1_high (out_t1_high),
		.out_flag0   (out_flag0),
		.out_flag1   (out_flag1),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #2 clk = ~clk;

	// Receiver: a long hold-off, once requested, overrides the random stall.
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_off  <= 79;
			out_stall <= 1'b1;
		end else if (hold_off > 0) begin
			out_stall <= 1'b1;
			hold_off  <= hold_off - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		dtc8051_pkg::result_t act;
		if (arst_n && out_valid && !out_stall) begin
			act.t0_low  = out_t0_low;
			act.t0_high = out_t0_high;
			act.t1_low  = out_t1_low;
			act.t1_high = out_t1_high;
			act.flag0   = out_flag0;
			act.flag1   = out_flag1;
			sb.check_result(act);
		end
	end

	task automatic send_item(dtc8051_pkg::op_t o, dtc8051_pkg::sel_t s, logic [7:0] d,
			logic [7:0] c, logic r0, logic r1);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		op         <= o;
		reg_select <= s;
		write_data <= d;
		cycles     <= c;
		run_timer0 <= r0;
		run_timer1 <= r1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_item(o, s, d, c, r0, r1);
	endtask

	// Drops valid and waits until every result is back and the pipe is empty.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, dtc8051_pkg::mode_t m);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_mode(idx, m);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_modes(dtc8051_pkg::mode_t m0, dtc8051_pkg::mode_t m1);
		drain();
		write_cfg(dtc8051_pkg::CFG_T0_MODE, m0);
		write_cfg(dtc8051_pkg::CFG_T1_MODE, m1);
	endtask

	task automatic send_random_item();
		int pick;
		dtc8051_pkg::op_t o;
		logic [7:0] c;
		pick = $urandom_range(99);
		if (pick < 70) begin
			o = dtc8051_pkg::OP_TICK;
		end else if (pick < 90) begin
			o = dtc8051_pkg::OP_WRITE;
		end else begin
			o = dtc8051_pkg::OP_CLEAR;
		end
		// Some short ticks so that counts creep up to their limits, plus full and random ones.
		pick = $urandom_range(7);
		if (pick < 2) begin
			c = 8'($urandom_range(15));
		end else if (pick == 2) begin
			c = 8'hFF;
		end else begin
			c = 8'($urandom_range(255));
		end
		send_item(o, dtc8051_pkg::sel_t'(2'($urandom_range(3))), 8'($urandom_range(255)), c,
			$urandom_range(3) != 0, $urandom_range(3) != 0);
	endtask

	initial begin
		int idle_profile;
		sb = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// 13-bit mode: wrap of both timers, low byte upper bits dropped.
		send_item(dtc8051_pkg::OP_WRITE, dtc8051_pkg::SEL_T0_LO, 8'hFF, 8'hAA, 1'b1, 1'b1);
		send_item(dtc8051_pkg::OP_WRITE, dtc8051_pkg::SEL_T0_HI, 8'hFF, 8'h00, 1'b0, 1'b0);
		send_item(dtc8051_pkg::OP_WRITE, dtc8051_pkg::SEL_T1_LO, 8'hE0, 8'h00, 1'b0, 1'b0);
		send_item(dtc8051_pkg::OP_WRITE, dtc8051_pkg::SEL_T1_HI, 8'hFF, 8'h00, 1'b0, 1'b0);
		send_item(dtc8051_pkg::OP_TICK, dtc8051_pkg::SEL_T0_LO, 8'h00, 8'hFF, 1'b1, 1'b1);
		send_item(dtc8051_pkg::OP_TICK, dtc8051_pkg::SEL_T0_LO, 8'h00, 8'h00, 1'b1, 1'b1);
		send_item(dtc8051_pkg::OP_TICK, dtc8051_pkg::SEL_T0_LO, 8'h00, 8'd200, 1'b0, 1'b0);
		send_item(dtc8051_pkg::OP_CLEAR, dtc8051_pkg::SEL_T0_LO, 8'h01, 8'h00, 1'b0, 1'b0);
		send_item(dtc8051_pkg::OP_CLEAR, dtc8051_pkg::SEL_T1_HI, 8'h02, 8'hFF, 1'b1, 1'b1);

		set_modes(dtc8051_pkg::MODE_16BIT, dtc8051_pkg::MODE_RELOAD);
		send_item(dtc8051_pkg::OP_WRITE, dtc8051_pkg::SEL_T0_LO, 8'hFF, 8'h00, 1'b0, 1'b0);
		send_item(dtc8051_pkg::OP_WRITE, dtc8051_pkg::SEL_T0_HI, 8'hFF, 8'h00, 1'b0, 1'b0);
		send_item(dtc8051_pkg::OP_WRITE, dtc8051_pkg::SEL_T1_HI, 8'h80, 8'h00, 1'b0, 1'b0);
		send_item(dtc8051_pkg::OP_WRITE, dtc8051_pkg::SEL_T1_LO, 8'hF0, 8'h00, 1'b0, 1'b0);
		send_item(dtc8051_pkg::OP_TICK, dtc8051_pkg::SEL_T0_LO, 8'h00, 8'hFF, 1'b1, 1'b1);
		send_item(dtc8051_pkg::OP_TICK, dtc8051_pkg::SEL_T0_LO, 8'h00, 8'h01, 1'b0, 1'b1);

		// Split timer 0 with timer 1 halted.
		set_modes(dtc8051_pkg::MODE_SPLIT, dtc8051_pkg::MODE_SPLIT);
		send_item(dtc8051_pkg::OP_CLEAR, dtc8051_pkg::SEL_T0_LO, 8'hFF, 8'h00, 1'b0, 1'b0);
		send_item(dtc8051_pkg::OP_TICK, dtc8051_pkg::SEL_T0_LO, 8'h00, 8'hFF, 1'b1, 1'b0);
		send_item(dtc8051_pkg::OP_TICK, dtc8051_pkg::SEL_T0_LO, 8'h00, 8'hFF, 1'b0, 1'b1);
		send_item(dtc8051_pkg::OP_TICK, dtc8051_pkg::SEL_T0_LO, 8'h00, 8'd128, 1'b1, 1'b1);

		// Timer 1 overflows while timer 0 is split and must not set its flag.
		set_modes(dtc8051_pkg::MODE_SPLIT, dtc8051_pkg::MODE_RELOAD);
		send_item(dtc8051_pkg::OP_CLEAR, dtc8051_pkg::SEL_T0_LO, 8'h03, 8'h00, 1'b0, 1'b0);
		send_item(dtc8051_pkg::OP_WRITE, dtc8051_pkg::SEL_T1_LO, 8'hFF, 8'h00, 1'b0, 1'b0);
		send_item(dtc8051_pkg::OP_TICK, dtc8051_pkg::SEL_T0_LO, 8'h00, 8'h01, 1'b0, 1'b1);
		send_item(dtc8051_pkg::OP_TICK, dtc8051_pkg::SEL_T0_LO, 8'h00, 8'hFF, 1'b1, 1'b1);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_modes(dtc8051_pkg::mode_t'(2'(p % 4)), dtc8051_pkg::mode_t'(2'(p / 4)));
			idle_profile = (p + p / 4) % 4;
			case (idle_profile)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			// Once, hold the output long enough for the input to back up.
			if (p == 4) hold_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_random_item();
			end
		end

		drain();
		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#(2_000_000);
		$display("Mismatches found");
		$finish;
	end
endmodule
